// File: rtl/swt_pkg.sv
// Shared types and constants of the shell word tokenizer.
// Holds result codes, quote modes and the result bundle passed from lexer to emitter.
// No dependencies.
`default_nettype none

package swt_pkg;

  localparam int SPAN_W       = 13;
  localparam int MAX_LINE_DEF = 4096;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_WEND = 2'd1;
  localparam logic [1:0] KIND_EOL  = 2'd2;

  localparam logic [1:0] QM_NONE   = 2'd0;
  localparam logic [1:0] QM_SINGLE = 2'd1;
  localparam logic [1:0] QM_DOUBLE = 2'd2;

  // slot order inside a bundle, which is also the delivery order
  localparam int HIT_BYTE = 0;
  localparam int HIT_WEND = 1;
  localparam int HIT_EOL  = 2;
  localparam int HIT_N    = 3;

  typedef struct packed {
    logic [HIT_N-1:0]  hit;
    logic [7:0]        content;
    logic [SPAN_W-1:0] word_start;
    logic [SPAN_W-1:0] word_end;
    logic [1:0]        qmode;
    logic              expand;
    logic [SPAN_W-1:0] line_len;
    logic              complete;
  } swt_bundle_t;

endpackage

`default_nettype wire

// File: rtl/swt_in_if.sv
// Input channel of the shell word tokenizer: one command line byte per transfer.
// Valid/ready handshake; depends on nothing.
`default_nettype none

interface swt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       byte_valid;
  logic       line_end;

  modport source (output valid, output char_byte, output byte_valid, output line_end,
                  input ready);
  modport sink   (input valid, input char_byte, input byte_valid, input line_end,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/swt_out_if.sv
// Result channel of the shell word tokenizer: one result per transfer.
// Valid/ready handshake; field widths from swt_pkg.
`default_nettype none

interface swt_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                result_kind;
  logic [7:0]                content_byte;
  logic [swt_pkg::SPAN_W-1:0] span_start;
  logic [swt_pkg::SPAN_W-1:0] span_end;
  logic [1:0]                quote_mode;
  logic                      expandable;
  logic                      line_complete;
  logic                      last_of_run;

  modport source (output valid, output result_kind, output content_byte, output span_start,
                  output span_end, output quote_mode, output expandable,
                  output line_complete, output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input content_byte, input span_start,
                  input span_end, input quote_mode, input expandable,
                  input line_complete, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/swt_lexer.sv
// Input register, lexer state and single-pass decode of one byte into a result bundle.
// Depends on swt_pkg and swt_in_if.
`default_nettype none

module swt_lexer #(
  parameter int MAX_LINE = swt_pkg::MAX_LINE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  swt_in_if.sink                    in_ch,
  output swt_pkg::swt_bundle_t      bnd,
  output logic                      bnd_valid,
  input  wire logic                 bnd_ready
);
  import swt_pkg::*;

  localparam int POS_W = $clog2(MAX_LINE + 1);
  localparam int EXT_W = SPAN_W + POS_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_WORD = 2'd1;
  localparam logic [1:0] MODE_SQ   = 2'd2;
  localparam logic [1:0] MODE_DQ   = 2'd3;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [SPAN_W-1:0] to_span(input logic [POS_W-1:0] p);
    logic [EXT_W-1:0] e;
    e = {{SPAN_W{1'b0}}, p};
    return e[SPAN_W-1:0];
  endfunction

  // input register
  logic       a_valid_r;
  logic [7:0] a_byte_r;
  logic       a_bvalid_r;
  logic       a_lend_r;
  logic       a_fire;

  // line state
  logic [1:0]       mode_r, mode_nxt;
  logic             esc_r, esc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] ws_r, ws_nxt;
  logic             sq_r, sq_nxt;
  logic             me_r, me_nxt;

  logic [1:0]       cur_mode;
  logic             unclosed;
  logic [POS_W-1:0] wend_pos;
  swt_bundle_t      bnd_c;

  assign in_ch.ready = !a_valid_r || a_fire;
  assign bnd_valid   = a_valid_r && (|bnd_c.hit);
  assign a_fire      = a_valid_r && (!(|bnd_c.hit) || bnd_ready);
  assign bnd         = bnd_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      a_byte_r   <= in_ch.char_byte;
      a_bvalid_r <= in_ch.byte_valid;
      a_lend_r   <= in_ch.line_end;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    pos_nxt  = pos_r;
    ws_nxt   = ws_r;
    sq_nxt   = sq_r;
    me_nxt   = me_r;
    cur_mode = mode_r;
    unclosed = 1'b0;
    wend_pos = pos_r;
    bnd_c    = '0;
    bnd_c.content = a_byte_r;

    if (a_bvalid_r) begin
      if (!(mode_r == MODE_IDLE && is_space(a_byte_r))) begin
        if (mode_r == MODE_IDLE) begin
          // open a new word at this byte
          ws_nxt   = pos_r;
          sq_nxt   = 1'b0;
          me_nxt   = 1'b1;
          cur_mode = MODE_WORD;
        end
        unique case (cur_mode)
          MODE_WORD: begin
            if (esc_r) begin
              esc_nxt = 1'b0;
              bnd_c.hit[HIT_BYTE] = 1'b1;
            end else if (a_byte_r == CH_SQUOTE) begin
              sq_nxt   = 1'b1;
              me_nxt   = 1'b0;
              mode_nxt = MODE_SQ;
            end else if (a_byte_r == CH_DQUOTE) begin
              sq_nxt   = 1'b1;
              me_nxt   = 1'b1;
              mode_nxt = MODE_DQ;
            end else if (a_byte_r == CH_BSLASH) begin
              // trailing backslash stays literal
              if (a_lend_r) bnd_c.hit[HIT_BYTE] = 1'b1;
              else          esc_nxt = 1'b1;
            end else if (is_space(a_byte_r)) begin
              bnd_c.hit[HIT_WEND] = 1'b1;
              mode_nxt = MODE_IDLE;
            end else begin
              bnd_c.hit[HIT_BYTE] = 1'b1;
              mode_nxt = MODE_WORD;
            end
          end
          MODE_SQ: begin
            if (a_byte_r == CH_SQUOTE) mode_nxt = MODE_WORD;
            else                       bnd_c.hit[HIT_BYTE] = 1'b1;
          end
          MODE_DQ: begin
            if (esc_r) begin
              esc_nxt = 1'b0;
              bnd_c.hit[HIT_BYTE] = 1'b1;
            end else if (a_byte_r == CH_DQUOTE) begin
              mode_nxt = MODE_WORD;
            end else begin
              bnd_c.hit[HIT_BYTE] = 1'b1;
              if (a_byte_r == CH_BSLASH && !a_lend_r) esc_nxt = 1'b1;
            end
          end
          default: begin
            mode_nxt = mode_r;
          end
        endcase
        if (cur_mode == MODE_WORD && mode_r == MODE_IDLE && !bnd_c.hit[HIT_WEND]
            && mode_nxt == MODE_IDLE) begin
          mode_nxt = MODE_WORD;
        end
      end
      if (pos_r != POS_MAX) pos_nxt = pos_r + 1'b1;
    end

    if (a_lend_r) begin
      // a backslash held over from the previous byte is the line's last byte
      if (esc_nxt && mode_nxt == MODE_WORD) begin
        bnd_c.hit[HIT_BYTE] = 1'b1;
        bnd_c.content       = CH_BSLASH;
      end
      unclosed = (mode_nxt == MODE_SQ) || (mode_nxt == MODE_DQ);
      if (mode_nxt != MODE_IDLE) begin
        bnd_c.hit[HIT_WEND] = 1'b1;
        wend_pos = pos_nxt;
      end
      bnd_c.hit[HIT_EOL] = 1'b1;
      bnd_c.line_len     = to_span(pos_nxt);
      bnd_c.complete     = !unclosed;
    end

    bnd_c.word_start = to_span(ws_nxt);
    bnd_c.word_end   = to_span(wend_pos);
    bnd_c.qmode      = sq_nxt ? (me_nxt ? QM_DOUBLE : QM_SINGLE) : QM_NONE;
    bnd_c.expand     = me_nxt;

    if (a_lend_r) begin
      mode_nxt = MODE_IDLE;
      esc_nxt  = 1'b0;
      pos_nxt  = '0;
      ws_nxt   = '0;
      sq_nxt   = 1'b0;
      me_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      esc_r  <= 1'b0;
      pos_r  <= '0;
      ws_r   <= '0;
      sq_r   <= 1'b0;
      me_r   <= 1'b1;
    end else if (a_fire) begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      pos_r  <= pos_nxt;
      ws_r   <= ws_nxt;
      sq_r   <= sq_nxt;
      me_r   <= me_nxt;
    end
  end

`ifndef SYNTHESIS
  a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
    a_fire && a_lend_r |=> mode_r == MODE_IDLE && pos_r == '0 && !esc_r)
    else $error("line state not cleared after line end");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX && ws_r <= pos_r)
    else $error("position out of range");

  a_esc_mode: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> mode_r == MODE_WORD || mode_r == MODE_DQ)
    else $error("escape pending outside a word or double quotes");
`endif

endmodule

`default_nettype wire

// File: rtl/swt_emitter.sv
// Result register of the shell word tokenizer: holds one bundle and sends its results in order.
// Depends on swt_pkg and swt_out_if.
`default_nettype none

module swt_emitter (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire swt_pkg::swt_bundle_t bnd,
  input  wire logic                 bnd_valid,
  output logic                      bnd_ready,
  swt_out_if.source                 out_ch
);
  import swt_pkg::*;

  logic [HIT_N-1:0] mask_r, mask_nxt;
  swt_bundle_t      held_r;
  logic [HIT_N-1:0] pick;
  logic             out_fire;
  logic             last;

  assign pick     = mask_r & (~mask_r + 1'b1);
  assign last     = (mask_r & ~pick) == '0;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign bnd_ready = (mask_r == '0) || (out_fire && last);

  always_comb begin
    mask_nxt = mask_r;
    if (out_fire) mask_nxt = mask_r & ~pick;
    if (bnd_valid && bnd_ready) mask_nxt = bnd.hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (bnd_valid && bnd_ready) held_r <= bnd;
  end

  always_comb begin
    out_ch.valid         = |mask_r;
    out_ch.last_of_run   = last;
    out_ch.result_kind   = KIND_BYTE;
    out_ch.content_byte  = '0;
    out_ch.span_start    = '0;
    out_ch.span_end      = '0;
    out_ch.quote_mode    = QM_NONE;
    out_ch.expandable    = 1'b0;
    out_ch.line_complete = 1'b0;
    if (pick[HIT_BYTE]) begin
      out_ch.content_byte = held_r.content;
    end else if (pick[HIT_WEND]) begin
      out_ch.result_kind = KIND_WEND;
      out_ch.span_start  = held_r.word_start;
      out_ch.span_end    = held_r.word_end;
      out_ch.quote_mode  = held_r.qmode;
      out_ch.expandable  = held_r.expand;
    end else if (pick[HIT_EOL]) begin
      out_ch.result_kind   = KIND_EOL;
      out_ch.span_start    = held_r.line_len;
      out_ch.span_end      = held_r.line_len;
      out_ch.line_complete = held_r.complete;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    bnd_valid && bnd_ready |-> mask_r == '0 || (out_fire && $countones(mask_r) == 1))
    else $error("bundle loaded over pending results");

  a_keep_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_ch.last_of_run |=> out_ch.valid)
    else $error("run ended before its last result");

  a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.result_kind == KIND_EOL |-> out_ch.last_of_run)
    else $error("end of line not last of its run");
`endif

endmodule

`default_nettype wire

// File: rtl/shell_word_tokenizer_core.sv
// Shell word tokenizer: splits a command line, one byte per transfer, into word results.
// Top level; instantiates swt_lexer and swt_emitter, uses swt_pkg and the channel interfaces.
//
// Usage:
//   in_ch  carries char_byte, byte_valid and line_end; a transfer with byte_valid low
//          and line_end high closes the line without a byte, one with both low is a no-op.
//   out_ch carries one result per transfer: content byte, word end (span, quote mode,
//          expandable) or end of line (length, complete); last_of_run marks the final
//          result caused by one input transfer.
//   Path: an item's first result passes the input register, then the result register.
//   Throughput: one item per cycle while each item causes at most one result and
//   out_ch.ready stays high; an item with several results holds the result register
//   until all are sent, one result per cycle while out_ch.ready is high. An item that
//   causes no result never waits on the output. A new item is taken while the results
//   of the previous one wait at the output.
//   Stall: with out_ch.ready low the pending result holds, the lexer holds one item,
//   and in_ch.ready drops once both registers are full.
//   Reset: synchronous, active low; returns the lexer to the start of a line and empties
//   both registers. No clearing pass.
//   MAX_LINE sets the saturating position counter width; span fields are 13 bits.
`default_nettype none

module shell_word_tokenizer_core #(
  parameter int MAX_LINE = swt_pkg::MAX_LINE_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  swt_in_if.sink    in_ch,
  swt_out_if.source out_ch
);
  import swt_pkg::*;

  swt_bundle_t bnd;
  logic        bnd_valid;
  logic        bnd_ready;

  swt_lexer #(
    .MAX_LINE (MAX_LINE)
  ) u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .bnd       (bnd),
    .bnd_valid (bnd_valid),
    .bnd_ready (bnd_ready)
  );

  swt_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .bnd       (bnd),
    .bnd_valid (bnd_valid),
    .bnd_ready (bnd_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking bench for shell_word_tokenizer_core: drives byte items, predicts the
// word and line results in the bench, and compares every result field by field.
// Depends on shell_word_tokenizer_core, swt_pkg, swt_in_if and swt_out_if.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swt_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LINE_CAP    = MAX_LINE_DEF;
  localparam int RANDOM_ITEMS = 135;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [1:0] {LX_GAP, LX_BARE, LX_SQUOTE, LX_DQUOTE} lex_state_t;

  typedef struct {
    logic [7:0] char_byte;
    logic       byte_valid;
    logic       line_end;
    bit         wait_drain;
  } line_item_t;

  typedef struct {
    logic [1:0]        kind;
    logic [7:0]        content;
    logic [SPAN_W-1:0] span_start;
    logic [SPAN_W-1:0] span_end;
    logic [1:0]        qmode;
    logic              expand;
    logic              complete;
    logic              last;
  } token_result_t;

  logic clk;
  logic rst_n;

  swt_in_if  in_ch ();
  swt_out_if out_ch ();

  shell_word_tokenizer_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  line_item_t    pending_items[$];
  token_result_t expected_results[$];
  token_result_t step_results[$];
  line_item_t    cur_item;

  int error_count;
  int items_taken;
  int results_seen;
  int real_items;
  bit drain_next;

  // tokenizer state held by the bench
  lex_state_t lx;
  bit         esc_pend;
  int         pos;
  int         word_start;
  bit         quoted;
  bit         expand_ok;

  // ---------------------------------------------------------------- prediction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= 8'h0D);
  endfunction

  task automatic clear_line();
    lx         = LX_GAP;
    esc_pend   = 1'b0;
    pos        = 0;
    word_start = 0;
    quoted     = 1'b0;
    expand_ok  = 1'b1;
  endtask

  task automatic push_res(logic [1:0] kind, logic [7:0] b, int s, int e, logic [1:0] qm,
                          logic ex, logic lc);
    token_result_t r;
    r.kind       = kind;
    r.content    = b;
    r.span_start = s[SPAN_W-1:0];
    r.span_end   = e[SPAN_W-1:0];
    r.qmode      = qm;
    r.expand     = ex;
    r.complete   = lc;
    r.last       = 1'b0;
    step_results.push_back(r);
  endtask

  task automatic emit_content(logic [7:0] c);
    push_res(KIND_BYTE, c, 0, 0, QM_NONE, 1'b0, 1'b0);
  endtask

  task automatic close_word(int end_pos);
    logic [1:0] qm;
    qm = quoted ? (expand_ok ? QM_DOUBLE : QM_SINGLE) : QM_NONE;
    push_res(KIND_WEND, 8'h00, word_start, end_pos, qm, expand_ok, 1'b0);
  endtask

  task automatic take_byte(logic [7:0] c, logic last);
    if (lx == LX_GAP) begin
      if (is_blank(c)) return;
      word_start = pos;
      quoted     = 1'b0;
      expand_ok  = 1'b1;
      lx         = LX_BARE;
    end
    case (lx)
      LX_BARE: begin
        if (esc_pend) begin
          esc_pend = 1'b0;
          emit_content(c);
        end else if (c == CH_SQUOTE) begin
          quoted    = 1'b1;
          expand_ok = 1'b0;
          lx        = LX_SQUOTE;
        end else if (c == CH_DQUOTE) begin
          quoted    = 1'b1;
          expand_ok = 1'b1;
          lx        = LX_DQUOTE;
        end else if (c == CH_BSLASH) begin
          // a backslash closing the line is kept as is
          if (last) emit_content(c);
          else esc_pend = 1'b1;
        end else if (is_blank(c)) begin
          close_word(pos);
          lx = LX_GAP;
        end else begin
          emit_content(c);
        end
      end
      LX_SQUOTE: begin
        if (c == CH_SQUOTE) lx = LX_BARE;
        else emit_content(c);
      end
      default: begin
        if (esc_pend) begin
          esc_pend = 1'b0;
          emit_content(c);
        end else if (c == CH_DQUOTE) begin
          lx = LX_BARE;
        end else if (c == CH_BSLASH) begin
          // pass the backslash through, then the byte after it
          emit_content(c);
          if (!last) esc_pend = 1'b1;
        end else begin
          emit_content(c);
        end
      end
    endcase
  endtask

  task automatic tokenize_item(line_item_t it);
    logic          unclosed;
    token_result_t r;
    step_results.delete();
    if (it.byte_valid) begin
      take_byte(it.char_byte, it.line_end);
      if (pos < LINE_CAP) pos++;
    end
    if (it.line_end) begin
      if (esc_pend && lx == LX_BARE) emit_content(CH_BSLASH);
      esc_pend = 1'b0;
      unclosed = (lx == LX_SQUOTE || lx == LX_DQUOTE);
      if (lx != LX_GAP) close_word(pos);
      push_res(KIND_EOL, 8'h00, pos, pos, QM_NONE, 1'b0, !unclosed);
      clear_line();
    end
    foreach (step_results[i]) begin
      r      = step_results[i];
      r.last = (i == step_results.size() - 1);
      expected_results.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_error(string msg);
    if (error_count < 50) $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [SPAN_W-1:0] got, logic [SPAN_W-1:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %0d, want %0d", results_seen, name, got,
                             want));
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic put_item(logic [7:0] b, logic v, logic e, bit d);
    line_item_t it;
    it.char_byte  = b;
    it.byte_valid = v;
    it.line_end   = e;
    it.wait_drain = d;
    pending_items.push_back(it);
    if (v || e) real_items++;
  endtask

  task automatic put_text(string s, bit close);
    for (int i = 0; i < s.len(); i++) put_item(s[i], 1'b1, close && i == s.len() - 1, 1'b0);
  endtask

  function automatic logic [7:0] blank_byte();
    return ($urandom_range(0, 5) == 5) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (is_blank(b) || b == CH_SQUOTE || b == CH_DQUOTE || b == CH_BSLASH);
    return b;
  endfunction

  // One command line: mostly well-formed words built of plain, escaped and quoted
  // parts; now and then a quote or escape is cut off, or the line is plain noise.
  task automatic gen_line(bit noise);
    logic [7:0] line_q[$];
    logic [7:0] b;
    int         n_words;
    int         n_parts;
    bit         cut;
    bit         end_on_byte;
    bit         drain;
    cut = 1'b0;
    if (noise) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      n_words = $urandom_range(0, 4);
      for (int w = 0; w < n_words && !cut; w++) begin
        repeat ($urandom_range(w == 0 ? 0 : 1, 2)) line_q.push_back(blank_byte());
        n_parts = $urandom_range(1, 3);
        for (int p = 0; p < n_parts && !cut; p++) begin
          case ($urandom_range(0, 4))
            0: repeat ($urandom_range(1, 4)) line_q.push_back(word_byte());
            1: begin
              line_q.push_back(CH_BSLASH);
              cut = ($urandom_range(0, 9) == 0);
              if (!cut) line_q.push_back(8'($urandom_range(0, 255)));
            end
            2: begin
              line_q.push_back(CH_SQUOTE);
              repeat ($urandom_range(0, 3)) begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_SQUOTE);
                line_q.push_back(b);
              end
              cut = ($urandom_range(0, 9) == 0);
              if (!cut) line_q.push_back(CH_SQUOTE);
            end
            3: begin
              line_q.push_back(CH_DQUOTE);
              repeat ($urandom_range(0, 3)) begin
                case ($urandom_range(0, 4))
                  0: begin
                    line_q.push_back(CH_BSLASH);
                    line_q.push_back(8'($urandom_range(0, 255)));
                  end
                  1: line_q.push_back(CH_SQUOTE);
                  2: line_q.push_back(blank_byte());
                  default: line_q.push_back(word_byte());
                endcase
              end
              cut = ($urandom_range(0, 9) == 0);
              if (!cut) line_q.push_back(CH_DQUOTE);
            end
            default: line_q.push_back($urandom_range(0, 1) ? 8'h00 : 8'hFF);
          endcase
        end
      end
      if (!cut && $urandom_range(0, 3) == 0) line_q.push_back(blank_byte());
    end
    drain       = drain_next || ($urandom_range(0, 7) == 0);
    drain_next  = 1'b0;
    end_on_byte = (line_q.size() > 0) && ($urandom_range(0, 1) == 1);
    foreach (line_q[i]) begin
      if ($urandom_range(0, 11) == 0) put_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
      put_item(line_q[i], 1'b1, end_on_byte && i == line_q.size() - 1, drain && i == 0);
    end
    if (!end_on_byte) put_item(8'($urandom_range(0, 255)), 1'b0, 1'b1,
                               drain && line_q.size() == 0);
  endtask

  // ---------------------------------------------------------------- clock and reset

  initial begin : clock_gen
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.char_byte   = 8'h00;
    in_ch.byte_valid  = 1'b0;
    in_ch.line_end    = 1'b0;
    out_ch.ready      = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : drive_proc
    bit offer;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        tokenize_item(cur_item);
        items_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        offer = pending_items.size() > 0 &&
                ((items_taken >= 60 && items_taken < 110) || $urandom_range(0, 99) >= 18);
        // hold this item until the block has delivered everything owed so far
        if (offer && pending_items[0].wait_drain && expected_results.size() > 0) offer = 1'b0;
        if (offer) begin
          cur_item          = pending_items.pop_front();
          in_ch.char_byte  <= cur_item.char_byte;
          in_ch.byte_valid <= cur_item.byte_valid;
          in_ch.line_end   <= cur_item.line_end;
        end
        in_ch.valid <= offer;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : watch_proc
    token_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("result %0d of kind %0d with nothing expected", results_seen,
                                 out_ch.result_kind));
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", SPAN_W'(out_ch.result_kind), SPAN_W'(want.kind));
          check_field("content_byte", SPAN_W'(out_ch.content_byte), SPAN_W'(want.content));
          check_field("span_start", out_ch.span_start, want.span_start);
          check_field("span_end", out_ch.span_end, want.span_end);
          check_field("quote_mode", SPAN_W'(out_ch.quote_mode), SPAN_W'(want.qmode));
          check_field("expandable", SPAN_W'(out_ch.expandable), SPAN_W'(want.expand));
          check_field("line_complete", SPAN_W'(out_ch.line_complete),
                      SPAN_W'(want.complete));
          check_field("last_of_run", SPAN_W'(out_ch.last_of_run), SPAN_W'(want.last));
        end
        results_seen++;
      end
      out_ch.ready <= (results_seen >= 100 && results_seen < 180) ||
                      $urandom_range(0, 99) >= 18;
    end
  end

  // ---------------------------------------------------------------- watchdog

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin : main_proc
    error_count  = 0;
    items_taken  = 0;
    results_seen = 0;
    real_items   = 0;
    drain_next   = 1'b0;
    clear_line();

    // no-op item, then a line with no bytes at all
    put_item(8'h5A, 1'b0, 1'b0, 1'b0);
    put_item(8'hA5, 1'b0, 1'b1, 1'b0);
    // trailing backslash closed by an empty line end
    put_text("a\\", 1'b0);
    put_item(8'h00, 1'b0, 1'b1, 1'b0);
    // empty single-quoted word, then empty double-quoted word ending the line
    put_text("''", 1'b0);
    put_item(8'h0D, 1'b1, 1'b0, 1'b0);
    put_text("\"\"", 1'b1);
    // byte extremes and the edges of the whitespace range
    put_item(8'h00, 1'b1, 1'b0, 1'b0);
    put_item(8'hFF, 1'b1, 1'b0, 1'b0);
    put_item(8'h09, 1'b1, 1'b0, 1'b0);
    put_item(8'h08, 1'b1, 1'b0, 1'b0);
    put_item(8'h0E, 1'b1, 1'b0, 1'b0);
    put_item(8'h0B, 1'b1, 1'b0, 1'b0);
    put_text("q\\", 1'b1);
    // unclosed double quote with a backslash as the last byte
    put_text("\"a\\", 1'b1);
    // unclosed single quote
    put_text("x'y", 1'b1);

    real_items = 0;
    drain_next = 1'b1;
    while (real_items < RANDOM_ITEMS) gen_line($urandom_range(0, 4) == 0);
    gen_line(1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0);
    // allow for stray results from the two-stage pipe
    repeat (10) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
